>>> hdl/hctd_pkg.sv
package hctd_pkg;

    localparam int SQUARE_COUNT = 64;
    localparam int HALF_SIZE    = SQUARE_COUNT * SQUARE_COUNT;
    localparam int TABLE_SIZE   = 2 * HALF_SIZE;
    localparam int ADDR_W       = $clog2(TABLE_SIZE);

    localparam int OP_W     = 2;
    localparam int SQUARE_W = 6;
    localparam int DEPTH_W  = 7;
    localparam int DSQ_W    = 2 * DEPTH_W;
    localparam int ENTRY_W  = 15;

    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [ENTRY_W-1:0]  t_entry;
    typedef logic [OP_W-1:0]     t_op;
    typedef logic [SQUARE_W-1:0] t_square;
    typedef logic [DEPTH_W-1:0]  t_depth;

    localparam t_entry ENTRY_MAX   = '1;
    localparam t_entry LIMIT_RESET = ENTRY_W'(10000);

    localparam t_op OP_BUMP  = 2'd0;
    localparam t_op OP_READ  = 2'd1;
    localparam t_op OP_AGE   = 2'd2;
    localparam t_op OP_CLEAR = 2'd3;

    localparam t_addr ADDR_LAST      = ADDR_W'(TABLE_SIZE - 1);
    localparam t_addr HALF_BASE      = ADDR_W'(HALF_SIZE);
    localparam t_addr HALF_LAST_OFFS = ADDR_W'(HALF_SIZE - 1);

    typedef struct packed {
        logic   rd_en;
        t_addr  rd_addr;
        logic   wr_en;
        t_addr  wr_addr;
        t_entry wr_data;
    } t_mem_req;

    typedef struct packed {
        logic   load;
        t_entry value;
    } t_result;

    function automatic logic square_in_range(input t_square from_sq, input t_square to_sq);
        return (int'(from_sq) < SQUARE_COUNT) && (int'(to_sq) < SQUARE_COUNT);
    endfunction

    function automatic t_addr table_index(input logic side, input t_square from_sq,
                                          input t_square to_sq);
        t_addr base;
        base = side ? HALF_BASE : '0;
        return base + ADDR_W'(from_sq) * ADDR_W'(SQUARE_COUNT) + ADDR_W'(to_sq);
    endfunction

endpackage

>>> hdl/hctd_ram.sv
module hctd_ram #(
    parameter int DATA_W = 15,
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/hctd_ctrl.sv
module hctd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  hctd_pkg::t_op     i_opcode,
    input  logic              i_side,
    input  hctd_pkg::t_square i_from_square,
    input  hctd_pkg::t_square i_to_square,
    input  hctd_pkg::t_depth  i_depth,
    input  hctd_pkg::t_entry  i_limit,
    input  logic              i_out_free,
    output hctd_pkg::t_result o_result,
    output hctd_pkg::t_mem_req o_mem,
    input  hctd_pkg::t_entry  i_rd_data
);
    import hctd_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CALC  = 2'd1;
    localparam logic [1:0] S_HALVE = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;

    logic [1:0]       r_state, n_state;
    logic             r_rd_done, n_rd_done;
    logic             r_wb_valid, n_wb_valid;
    t_addr            r_sw_addr, n_sw_addr;
    t_addr            r_sw_last, n_sw_last;
    t_addr            r_wb_addr, n_wb_addr;
    t_op              r_op, n_op;
    logic             r_side, n_side;
    logic             r_in_range, n_in_range;
    t_addr            r_idx, n_idx;
    logic [DSQ_W-1:0] r_dsq, n_dsq;

    logic [ENTRY_W:0] sum;
    t_entry           bumped;
    logic             over;

    always_comb begin
        sum    = {1'b0, i_rd_data} + (ENTRY_W + 1)'(r_dsq);
        bumped = (sum > (ENTRY_W + 1)'(ENTRY_MAX)) ? ENTRY_MAX : sum[ENTRY_W-1:0];
        over   = bumped > i_limit;
    end

    always_comb begin
        n_state    = r_state;
        n_rd_done  = r_rd_done;
        n_wb_valid = r_wb_valid;
        n_sw_addr  = r_sw_addr;
        n_sw_last  = r_sw_last;
        n_wb_addr  = r_wb_addr;
        n_op       = r_op;
        n_side     = r_side;
        n_in_range = r_in_range;
        n_idx      = r_idx;
        n_dsq      = r_dsq;
        o_mem      = '0;
        o_result   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = table_index(i_side, i_from_square, i_to_square);
                    n_idx         = o_mem.rd_addr;
                    n_op          = i_opcode;
                    n_side        = i_side;
                    n_in_range    = square_in_range(i_from_square, i_to_square);
                    n_dsq         = DSQ_W'(i_depth) * DSQ_W'(i_depth);
                    n_state       = S_CALC;
                end
            end
            S_CALC: begin
                if (i_out_free) begin
                    o_result.load = 1'b1;
                    n_state       = S_IDLE;
                    n_sw_addr     = '0;
                    n_sw_last     = ADDR_LAST;
                    n_rd_done     = 1'b0;
                    n_wb_valid    = 1'b0;
                    case (r_op)
                        OP_BUMP: begin
                            if (r_in_range) begin
                                o_mem.wr_en   = 1'b1;
                                o_mem.wr_addr = r_idx;
                                o_mem.wr_data = bumped;
                                if (over) begin
                                    o_result.value = bumped >> 1;
                                    n_sw_addr      = r_side ? HALF_BASE : '0;
                                    n_sw_last      = n_sw_addr + HALF_LAST_OFFS;
                                    n_state        = S_HALVE;
                                end else begin
                                    o_result.value = bumped;
                                end
                            end
                        end
                        OP_READ: begin
                            if (r_in_range) begin
                                o_result.value = i_rd_data;
                            end
                        end
                        OP_AGE: begin
                            n_state = S_HALVE;
                        end
                        default: begin
                            n_state = S_CLEAR;
                        end
                    endcase
                end
            end
            S_HALVE: begin
                if (r_wb_valid) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_wb_addr;
                    o_mem.wr_data = i_rd_data >> 1;
                end
                if (!r_rd_done) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_sw_addr;
                    n_wb_addr     = r_sw_addr;
                    n_wb_valid    = 1'b1;
                    n_sw_addr     = r_sw_addr + ADDR_W'(1);
                    if (r_sw_addr == r_sw_last) begin
                        n_rd_done = 1'b1;
                    end
                end else begin
                    n_wb_valid = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            S_CLEAR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_sw_addr;
                o_mem.wr_data = '0;
                n_sw_addr     = r_sw_addr + ADDR_W'(1);
                if (r_sw_addr == r_sw_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_rd_done  <= 1'b0;
            r_wb_valid <= 1'b0;
            r_sw_addr  <= '0;
            r_sw_last  <= ADDR_LAST;
        end else begin
            r_state    <= n_state;
            r_rd_done  <= n_rd_done;
            r_wb_valid <= n_wb_valid;
            r_sw_addr  <= n_sw_addr;
            r_sw_last  <= n_sw_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_addr  <= n_wb_addr;
        r_op       <= n_op;
        r_side     <= n_side;
        r_in_range <= n_in_range;
        r_idx      <= n_idx;
        r_dsq      <= n_dsq;
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> hdl/history_counter_table_with_decay_top.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// in       | input     | i_in_valid/o_in_stall  | opcode, side, from_square, to_square, depth
// out      | output    | o_out_valid/i_out_stall | entry_value
// cfg      | input     | i_cfg_valid/o_cfg_ready | overflow_limit
//
// A bump or read first reads the table, then modifies and writes back (bump only) and
// loads the output register, which holds one beat while the next item is taken.
// An age, or a bump that passes the limit, then sweeps the table port one entry a cycle,
// halving the whole table for an age and only the bumped side for such a bump. A clear
// zeroes the whole table, and after reset the same clearing pass runs before any item
// is accepted. A stalled output holds the block in its modify cycle until the beat is taken.
module history_counter_table_with_decay_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  hctd_pkg::t_op              i_opcode,
    input  logic                       i_side,
    input  hctd_pkg::t_square          i_from_square,
    input  hctd_pkg::t_square          i_to_square,
    input  hctd_pkg::t_depth           i_depth,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output hctd_pkg::t_entry           o_entry_value,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  hctd_pkg::t_entry           i_cfg_data
);
    import hctd_pkg::*;

    t_entry   r_limit;
    logic     r_out_valid;
    t_entry   r_out_value;
    t_result  result;
    t_mem_req mem;
    t_entry   rd_data;
    logic     out_free;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.load) begin
            r_out_value <= result.value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_value = r_out_value;

    hctd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_side        (i_side),
        .i_from_square (i_from_square),
        .i_to_square   (i_to_square),
        .i_depth       (i_depth),
        .i_limit       (r_limit),
        .i_out_free    (out_free),
        .o_result      (result),
        .o_mem         (mem),
        .i_rd_data     (rd_data)
    );

    hctd_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (TABLE_SIZE),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (mem.rd_en),
        .i_rd_addr (mem.rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (mem.wr_en),
        .i_wr_addr (mem.wr_addr),
        .i_wr_data (mem.wr_data)
    );

endmodule
